[rtl/tia_pkg.sv]
// ---------------------------------------------------------------------------
// tia_pkg: shared types and constants for the typed integer ALU
// Opcodes, type kinds and the classified operation record passed from the
// front end to the execution back end.
// ---------------------------------------------------------------------------
`default_nettype none
package tia_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned SHAMT_W = 6;

    localparam logic [4:0] FN_ADD  = 5'd0;
    localparam logic [4:0] FN_SUB  = 5'd1;
    localparam logic [4:0] FN_MUL  = 5'd2;
    localparam logic [4:0] FN_SDIV = 5'd3;
    localparam logic [4:0] FN_SREM = 5'd4;
    localparam logic [4:0] FN_AND  = 5'd5;
    localparam logic [4:0] FN_OR   = 5'd6;
    localparam logic [4:0] FN_XOR  = 5'd7;
    localparam logic [4:0] FN_SHL  = 5'd8;
    localparam logic [4:0] FN_ASHR = 5'd9;
    localparam logic [4:0] FN_LSHR = 5'd10;
    localparam logic [4:0] FN_NEG  = 5'd11;
    localparam logic [4:0] FN_NOT  = 5'd12;
    localparam logic [4:0] FN_EQ   = 5'd13;
    localparam logic [4:0] FN_NE   = 5'd14;
    localparam logic [4:0] FN_LT   = 5'd15;
    localparam logic [4:0] FN_LE   = 5'd16;
    localparam logic [4:0] FN_GT   = 5'd17;
    localparam logic [4:0] FN_GE   = 5'd18;

    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_BOOL = 2'd1;

    // execution class chosen by the front end
    localparam logic [1:0] CL_SIMPLE = 2'd0;  // result already final
    localparam logic [1:0] CL_MUL    = 2'd1;
    localparam logic [1:0] CL_DIV    = 2'd2;

    typedef struct packed {
        logic [1:0]        cls;
        logic              is_rem;
        logic              neg_res;    // negate magnitude result
        logic              typed;      // apply result type
        logic [1:0]        kind;
        logic [6:0]        bits;
        logic [WORD_W-1:0] x;          // simple result, or operand / magnitude
        logic [WORD_W-1:0] y;
    } t_op;

    // truncate to the result type; int widths are sign-extended from their top bit
    function automatic logic [WORD_W-1:0] apply_type(input logic [WORD_W-1:0] v,
                                                     input logic [1:0] kind,
                                                     input logic [6:0] bits);
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] u;
        logic [5:0]        top;
        begin
            mask = '1;
            u = v;
            top = 6'(bits - 7'd1);
            if (kind == KIND_BOOL) begin
                u = {{(WORD_W-1){1'b0}}, v[0]};
            end else if (kind == KIND_INT && bits != 7'd0 && bits < 7'd64) begin
                mask = ~({WORD_W{1'b1}} << bits[5:0]);
                u = v & mask;
                if (v[top]) begin
                    u = u | ~mask;
                end
            end
            apply_type = u;
        end
    endfunction

endpackage
`default_nettype wire

[rtl/tia_front.sv]
// ---------------------------------------------------------------------------
// tia_front: operation classifier
// Computes simple results outright and prepares operands for the
// multiplier and divider; registers one classified operation.
// ---------------------------------------------------------------------------
`default_nettype none
module tia_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [4:0]     i_func,
    input  wire logic [63:0]    i_operand_a,
    input  wire logic [63:0]    i_operand_b,
    input  wire logic [1:0]     i_type_kind,
    input  wire logic [6:0]     i_type_bits,
    output logic                o_valid,
    input  wire logic           i_stall,
    output tia_pkg::t_op        o_op
);

    logic         r_valid;
    tia_pkg::t_op r_op;
    tia_pkg::t_op n_op;
    logic [63:0]  a, b, ma, mb, v;
    logic         lt, gt, cmp, minov;

    assign a = i_operand_a;
    assign b = i_operand_b;
    assign ma = a[63] ? 64'(-a) : a;
    assign mb = b[63] ? 64'(-b) : b;
    assign lt = $signed(a) < $signed(b);
    assign gt = $signed(b) < $signed(a);
    assign minov = (a == 64'h8000_0000_0000_0000) && (b == '1);

    // classify and evaluate simple operations
    always_comb begin
        v = '0;
        cmp = 1'b0;
        n_op.cls = tia_pkg::CL_SIMPLE;
        n_op.is_rem = (i_func == tia_pkg::FN_SREM);
        n_op.neg_res = 1'b0;
        n_op.typed = 1'b1;
        n_op.kind = i_type_kind;
        n_op.bits = i_type_bits;
        n_op.y = '0;
        unique case (i_func)
            tia_pkg::FN_ADD:  v = a + b;
            tia_pkg::FN_SUB:  v = a - b;
            tia_pkg::FN_MUL: begin
                n_op.cls = tia_pkg::CL_MUL;
                v = a;
                n_op.y = b;
            end
            tia_pkg::FN_SDIV, tia_pkg::FN_SREM: begin
                if (b == '0) begin
                    n_op.typed = 1'b0;
                end else if (minov) begin
                    v = n_op.is_rem ? '0 : a;
                end else begin
                    n_op.cls = tia_pkg::CL_DIV;
                    v = ma;
                    n_op.y = mb;
                    n_op.neg_res = n_op.is_rem ? a[63] : (a[63] ^ b[63]);
                end
            end
            tia_pkg::FN_AND:  v = a & b;
            tia_pkg::FN_OR:   v = a | b;
            tia_pkg::FN_XOR:  v = a ^ b;
            tia_pkg::FN_SHL:  v = a << b[5:0];
            tia_pkg::FN_ASHR: v = 64'($signed(a) >>> b[5:0]);
            tia_pkg::FN_LSHR: v = a >> b[5:0];
            tia_pkg::FN_NEG:  v = 64'(-a);
            tia_pkg::FN_NOT:  v = ~a;
            tia_pkg::FN_EQ:   cmp = (a == b);
            tia_pkg::FN_NE:   cmp = (a != b);
            tia_pkg::FN_LT:   cmp = lt;
            tia_pkg::FN_LE:   cmp = !gt;
            tia_pkg::FN_GT:   cmp = gt;
            tia_pkg::FN_GE:   cmp = !lt;
            default:          n_op.typed = 1'b0;
        endcase
        if (i_func >= tia_pkg::FN_EQ && i_func <= tia_pkg::FN_GE) begin
            v = {63'd0, cmp};
            n_op.typed = 1'b0;
        end
        if (n_op.cls == tia_pkg::CL_SIMPLE && n_op.typed) begin
            v = tia_pkg::apply_type(v, i_type_kind, i_type_bits);
        end
        n_op.x = v;
    end

    assign o_stall = r_valid && i_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_op <= n_op;
        end
    end

    assign o_valid = r_valid;
    assign o_op = r_op;

endmodule
`default_nettype wire

[rtl/tia_queue.sv]
// ---------------------------------------------------------------------------
// tia_queue: short operation queue
// Two-entry FIFO between classifier and execution back end.
// ---------------------------------------------------------------------------
`default_nettype none
module tia_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  tia_pkg::t_op  i_op,
    output logic          o_valid,
    input  wire logic     i_stall,
    output tia_pkg::t_op  o_op
);

    tia_pkg::t_op r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push = i_valid && !o_stall;
    assign pop = o_valid && !i_stall;
    assign o_op = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_op;
        end
    end

endmodule
`default_nettype wire

[rtl/tia_back.sv]
// ---------------------------------------------------------------------------
// tia_back: execution back end
// Pipelined multiplier (32x32 partial products) and a pipelined radix-2
// divider, 64 stages; every item walks the same pipe in order.
// ---------------------------------------------------------------------------
`default_nettype none
module tia_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  tia_pkg::t_op     i_op,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_result
);

    localparam int unsigned DSTG = 64;

    typedef struct packed {
        logic [1:0]  cls;
        logic        is_rem;
        logic        neg_res;
        logic        typed;
        logic [1:0]  kind;
        logic [6:0]  bits;
    } t_tag;

    logic en;

    // stage 0: partial products
    logic        r_v0;
    t_tag        r_t0;
    logic [63:0] r_x0, r_y0;
    logic [63:0] r_ll, r_lh, r_hl;
    // stage 1: product
    logic        r_v1;
    t_tag        r_t1;
    logic [63:0] r_x1, r_y1;

    // divider stages
    logic        r_dv [DSTG+1];
    t_tag        r_dt [DSTG+1];
    logic [63:0] r_dq [DSTG+1];
    logic [63:0] r_dr [DSTG+1];
    logic [63:0] r_dd [DSTG+1];

    logic        r_ov;
    logic [63:0] r_out;
    logic [63:0] fin;

    assign o_stall = r_ov && i_stall;
    assign en = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
    end

    // multiplier partial products and sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t0 <= t_tag'({i_op.cls, i_op.is_rem, i_op.neg_res, i_op.typed,
                            i_op.kind, i_op.bits});
            r_x0 <= i_op.x;
            r_y0 <= i_op.y;
            r_ll <= 64'(i_op.x[31:0]) * 64'(i_op.y[31:0]);
            r_lh <= 64'(i_op.x[31:0]) * 64'(i_op.y[63:32]);
            r_hl <= 64'(i_op.x[63:32]) * 64'(i_op.y[31:0]);
            r_t1 <= r_t0;
            r_x1 <= (r_t0.cls == tia_pkg::CL_MUL)
                    ? r_ll + {r_lh[31:0] + r_hl[31:0], 32'd0} : r_x0;
            r_y1 <= r_y0;
        end
    end

    // divider entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dt[0] <= r_t1;
            r_dq[0] <= r_x1;
            r_dr[0] <= '0;
            r_dd[0] <= r_y1;
        end
    end

    // one restoring-division bit per stage; non-divide items pass through
    for (genvar s = 0; s < DSTG; s++) begin : g_div
        logic [64:0] rem_sh, diff;
        assign rem_sh = {r_dr[s], r_dq[s][63]};
        assign diff = rem_sh - {1'b0, r_dd[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else if (en) begin
                r_dv[s+1] <= r_dv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dt[s+1] <= r_dt[s];
                r_dd[s+1] <= r_dd[s];
                if (r_dt[s].cls == tia_pkg::CL_DIV) begin
                    if (!diff[64]) begin
                        r_dr[s+1] <= diff[63:0];
                        r_dq[s+1] <= {r_dq[s][62:0], 1'b1};
                    end else begin
                        r_dr[s+1] <= rem_sh[63:0];
                        r_dq[s+1] <= {r_dq[s][62:0], 1'b0};
                    end
                end else begin
                    r_dr[s+1] <= r_dr[s];
                    r_dq[s+1] <= r_dq[s];
                end
            end
        end
    end

    // sign fix and typing
    always_comb begin
        fin = r_dq[DSTG];
        if (r_dt[DSTG].cls == tia_pkg::CL_DIV) begin
            fin = r_dt[DSTG].is_rem ? r_dr[DSTG] : r_dq[DSTG];
            if (r_dt[DSTG].neg_res) begin
                fin = 64'(-fin);
            end
        end
        if (r_dt[DSTG].cls != tia_pkg::CL_SIMPLE && r_dt[DSTG].typed) begin
            fin = tia_pkg::apply_type(fin, r_dt[DSTG].kind, r_dt[DSTG].bits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[DSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= fin;
        end
    end

    assign o_valid = r_ov;
    assign o_result = r_out;

endmodule
`default_nettype wire

[rtl/typed_integer_alu.sv]
// ---------------------------------------------------------------------------
// typed_integer_alu: typed 64-bit integer ALU
// Front classifier, short queue and pipelined execution back end.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries opcode, two signed 64-bit
//   operands and the result type; output channel o_valid / i_stall carries
//   one typed 64-bit result per item, in order.
//   Throughput: one item per cycle when the output is not stalled.
//   Every opcode takes the same path. The path holds 70 registers
//   (front register, 2-deep queue head, 2 multiplier stages, divider
//   entry, 64 divider stages, output register) and the transfer edge
//   loads the first.
//   Reset clears all valid flags; no item is in flight afterwards.
//   When the receiver stalls, the back pipe holds as a whole, the queue
//   fills, and then the input stall rises; no transfer is lost.
// ---------------------------------------------------------------------------
`default_nettype none
module typed_integer_alu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [4:0]  i_func,
    input  wire logic [63:0] i_operand_a,
    input  wire logic [63:0] i_operand_b,
    input  wire logic [1:0]  i_type_kind,
    input  wire logic [6:0]  i_type_bits,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_result
);

    logic         f_valid, f_stall, q_valid, q_stall;
    tia_pkg::t_op f_op, q_op;

    tia_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_func, .i_operand_a, .i_operand_b, .i_type_kind, .i_type_bits,
        .o_valid(f_valid), .i_stall(f_stall), .o_op(f_op)
    );

    tia_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_stall(f_stall), .i_op(f_op),
        .o_valid(q_valid), .i_stall(q_stall), .o_op(q_op)
    );

    tia_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_stall(q_stall), .i_op(q_op),
        .o_valid, .i_stall, .o_result
    );

endmodule
`default_nettype wire
